@@ hdl/letterbox_touch_mapper_unit_defines.svh @@
// Assertion macros used by the checker file.
`ifndef LETTERBOX_TOUCH_MAPPER_UNIT_DEFINES_SVH
`define LETTERBOX_TOUCH_MAPPER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define LTTM_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("letterbox touch mapper check failed");

// Next-cycle implication.
`define LTTM_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("letterbox touch mapper check failed");

`endif

@@ hdl/lttm_pkg.sv @@
`default_nettype none
package lttm_pkg;

	localparam int DIM_W = 13;
	localparam int COORD_W = 15;
	localparam int OFF_W = 12;
	localparam int REG_IDX_W = 2;
	localparam logic [DIM_W-1:0] MAX_DIMENSION = 13'd8191;

	localparam logic [DIM_W-1:0] RST_SURFACE_WIDTH = 13'd1024;
	localparam logic [DIM_W-1:0] RST_SURFACE_HEIGHT = 13'd768;
	localparam logic [DIM_W-1:0] RST_ENGINE_WIDTH = 13'd0;
	localparam logic [DIM_W-1:0] RST_ENGINE_HEIGHT = 13'd0;

	// rect fit divider: (2*p + e) / 2e, 13-bit quotient
	localparam int RDIV_DEN_W = DIM_W + 1;
	localparam int RDIV_Q_W = DIM_W;
	localparam int RDIV_NUM_W = RDIV_DEN_W + RDIV_Q_W;
	// lane divider: d*eng / len, 13-bit quotient, clamped to eng - 1 in the lane
	localparam int LDIV_DEN_W = DIM_W;
	localparam int LDIV_Q_W = DIM_W;
	localparam int LDIV_NUM_W = LDIV_DEN_W + LDIV_Q_W;
	localparam int DIST_W = COORD_W - 1;
	localparam int PROD_W = DIST_W + DIM_W;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_SURFACE_WIDTH  = 2'd0,
		REG_SURFACE_HEIGHT = 2'd1,
		REG_ENGINE_WIDTH   = 2'd2,
		REG_ENGINE_HEIGHT  = 2'd3
	} reg_idx_t;

	// Fields carried alongside the rect fit divider
	typedef struct packed {
		logic [DIM_W-1:0] sw;
		logic [DIM_W-1:0] sh;
		logic [DIM_W-1:0] ew;
		logic [DIM_W-1:0] eh;
		logic wlim;
		logic fit;
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
	} rdiv_side_t;

	// Fields carried alongside one lane's divider
	typedef struct packed {
		logic signed [COORD_W-1:0] coord;
		logic [OFF_W-1:0] offset;
		logic [DIM_W-1:0] len;
		logic [DIM_W-1:0] eng;
		logic ovf;
	} lane_side_t;

	function automatic logic [DIM_W-1:0] sat_dim(input logic [DIM_W-1:0] v);
		return (v > MAX_DIMENSION) ? MAX_DIMENSION : v;
	endfunction

endpackage
`default_nettype wire

@@ hdl/lttm_div.sv @@
`default_nettype none
// Restoring divider, one quotient bit per stage, Q_W stages.
// Caller guarantees num < den << Q_W.
module lttm_div #(
	parameter int DEN_W = 13,
	parameter int Q_W = 13,
	parameter int SIDE_W = 1
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic en,
	input  wire logic in_valid,
	input  wire logic [DEN_W+Q_W-1:0] num,
	input  wire logic [DEN_W-1:0] den,
	input  wire logic [SIDE_W-1:0] side,
	output logic out_valid,
	output logic [Q_W-1:0] quot,
	output logic [SIDE_W-1:0] out_side
);
	localparam int NUM_W = DEN_W + Q_W;

	logic             v_q    [Q_W+1];
	logic [NUM_W-1:0] rem_q  [Q_W+1];
	logic [DEN_W-1:0] den_q  [Q_W+1];
	logic [Q_W-1:0]   quot_q [Q_W+1];
	logic [SIDE_W-1:0] side_q [Q_W+1];

	assign v_q[0] = in_valid;
	assign rem_q[0] = num;
	assign den_q[0] = den;
	assign quot_q[0] = '0;
	assign side_q[0] = side;

	for (genvar i = 0; i < Q_W; i++) begin : g_stage
		localparam int K = Q_W - 1 - i;
		logic [NUM_W-1:0] dsh;
		logic ge;

		// trial subtract of the shifted divisor
		assign dsh = {{Q_W{1'b0}}, den_q[i]} << K;
		assign ge = rem_q[i] >= dsh;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_q[i+1] <= 1'b0;
			end else if (en) begin
				v_q[i+1] <= v_q[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[i+1] <= ge ? (rem_q[i] - dsh) : rem_q[i];
				den_q[i+1] <= den_q[i];
				quot_q[i+1] <= quot_q[i] | (Q_W'(ge) << K);
				side_q[i+1] <= side_q[i];
			end
		end
	end

	assign out_valid = v_q[Q_W];
	assign quot = quot_q[Q_W];
	assign out_side = side_q[Q_W];

endmodule
`default_nettype wire

@@ hdl/lttm_lane.sv @@
`default_nettype none
// One axis: offset removal, scale multiply, divide by fitted length, clamp.
module lttm_lane (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic en,
	input  wire logic in_valid,
	input  wire logic signed [lttm_pkg::COORD_W-1:0] coord,
	input  wire logic [lttm_pkg::OFF_W-1:0] offset,
	input  wire logic [lttm_pkg::DIM_W-1:0] len,
	input  wire logic [lttm_pkg::DIM_W-1:0] eng,
	output logic out_valid,
	output logic [lttm_pkg::DIM_W-1:0] mapped,
	output logic signed [lttm_pkg::COORD_W-1:0] raw,
	output logic [lttm_pkg::OFF_W-1:0] out_offset,
	output logic [lttm_pkg::DIM_W-1:0] out_len
);
	localparam int DW = lttm_pkg::DIM_W;

	logic signed [lttm_pkg::COORD_W:0] diff;
	logic [lttm_pkg::DIST_W-1:0] gap;
	logic v_s1, v_s2, v_s3, dv;
	logic [lttm_pkg::DIST_W-1:0] dist_s1;
	lttm_pkg::lane_side_t side_s1, side_s2, div_side, dside;
	logic [lttm_pkg::PROD_W-1:0] prod_s2;
	logic ovf;
	logic [lttm_pkg::LDIV_NUM_W-1:0] dnum;
	logic [DW-1:0] dq, lim;
	logic [DW-1:0] mapped_s3;
	lttm_pkg::lane_side_t side_s3;

	function automatic logic [lttm_pkg::LDIV_NUM_W-1:0] len_shift(input logic [DW-1:0] l);
		return {l, {lttm_pkg::LDIV_Q_W{1'b0}}};
	endfunction

	// distance from the picture edge, zero when left of it
	assign diff = $signed({coord[lttm_pkg::COORD_W-1], coord})
		- $signed({4'b0, offset});
	assign gap = (diff > 0) ? diff[lttm_pkg::DIST_W-1:0] : '0;

	// overflow means the quotient is past the clamp anyway
	assign ovf = prod_s2 >= {1'b0, len_shift(side_s2.len)};
	assign dnum = ovf ? '0 : prod_s2[lttm_pkg::LDIV_NUM_W-1:0];

	always_comb begin
		div_side = side_s2;
		div_side.ovf = ovf;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= dv;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dist_s1 <= gap;
			side_s1 <= '{coord: coord, offset: offset, len: len, eng: eng, ovf: 1'b0};
			prod_s2 <= lttm_pkg::PROD_W'(dist_s1) * lttm_pkg::PROD_W'(side_s1.eng);
			side_s2 <= side_s1;
			mapped_s3 <= (dside.ovf || (dq > lim)) ? lim : dq;
			side_s3 <= dside;
		end
	end

	assign lim = dside.eng - DW'(1);

	lttm_div #(
		.DEN_W(lttm_pkg::LDIV_DEN_W),
		.Q_W(lttm_pkg::LDIV_Q_W),
		.SIDE_W($bits(lttm_pkg::lane_side_t))
	) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_valid(v_s2),
		.num(dnum),
		.den(side_s2.len),
		.side(div_side),
		.out_valid(dv),
		.quot(dq),
		.out_side(dside)
	);

	assign out_valid = v_s3;
	assign mapped = mapped_s3;
	assign raw = side_s3.coord;
	assign out_offset = side_s3.offset;
	assign out_len = side_s3.len;

endmodule
`default_nettype wire

@@ hdl/letterbox_touch_mapper_unit.sv @@
// Letterbox touch mapper.
// Request channel: req_valid with surface_x/surface_y; taken when req_valid is
// high and req_stall low. Response channel: rsp_valid with engine_x/engine_y,
// the fitted rectangle and degenerate; taken when rsp_valid is high and
// rsp_stall low. Exactly one response per request, in order.
// From request to response a request passes 2 fit stages, a 13-stage
// rectangle divider, a rectangle register, then per axis 2 lane stages,
// a 13-stage divider and a clamp stage, and the response register.
// Throughput is one request per cycle while no response is held by the receiver; all stages advance together.
// When the receiver stalls a valid response, the whole pipeline holds and
// req_stall rises in the same cycle; it falls once the response is taken.
// Configuration: wr_en writes wr_data to register wr_index (surface width,
// surface height, engine width, engine height) at the clock edge; write only
// while no request is in flight.
// Reset (arst_n low) empties the pipeline and restores 1024x768 surface and
// engine size zero (follow the surface).
`default_nettype none
module letterbox_touch_mapper_unit (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	output logic req_stall,
	input  wire logic signed [lttm_pkg::COORD_W-1:0] surface_x,
	input  wire logic signed [lttm_pkg::COORD_W-1:0] surface_y,
	output logic rsp_valid,
	input  wire logic rsp_stall,
	output logic signed [lttm_pkg::COORD_W-1:0] engine_x,
	output logic signed [lttm_pkg::COORD_W-1:0] engine_y,
	output logic [lttm_pkg::OFF_W-1:0] rect_left,
	output logic [lttm_pkg::OFF_W-1:0] rect_top,
	output logic [lttm_pkg::DIM_W-1:0] rect_width,
	output logic [lttm_pkg::DIM_W-1:0] rect_height,
	output logic degenerate,
	input  wire logic wr_en,
	input  wire logic [lttm_pkg::REG_IDX_W-1:0] wr_index,
	input  wire logic [lttm_pkg::DIM_W-1:0] wr_data
);
	localparam int DW = lttm_pkg::DIM_W;
	localparam int CW = lttm_pkg::COORD_W;

	logic adv;
	logic [DW-1:0] sw_q, sh_q, ew_q, eh_q;
	logic [DW-1:0] sw, sh, ew, eh;

	logic v_s1, v_s2, v_s3;
	lttm_pkg::rdiv_side_t side_s1, side_s2, side_c2;
	logic [2*DW-1:0] pa_s1, pb_s1;
	logic [lttm_pkg::RDIV_NUM_W-1:0] num_s2;
	logic [lttm_pkg::RDIV_DEN_W-1:0] den_s2;
	logic wlim_c;
	logic [2*DW-1:0] psel;
	logic [lttm_pkg::RDIV_DEN_W-1:0] dsel;

	logic rv;
	logic [DW-1:0] rq;
	lttm_pkg::rdiv_side_t rside;
	logic [DW-1:0] w_c, h_c, dw_c, dh_c;

	logic signed [CW-1:0] x_s3, y_s3;
	logic [lttm_pkg::OFF_W-1:0] left_s3, top_s3;
	logic [DW-1:0] w_s3, h_s3, ew_s3, eh_s3;

	logic xv, yv;
	logic [DW-1:0] xm, ym, xlen, ylen;
	logic signed [CW-1:0] xraw, yraw;
	logic [lttm_pkg::OFF_W-1:0] xoff, yoff;
	logic degen;

	logic rsp_valid_q, degen_q;
	logic signed [CW-1:0] ex_q, ey_q;
	logic [lttm_pkg::OFF_W-1:0] left_q, top_q;
	logic [DW-1:0] w_q, h_q;

	// whole pipeline moves unless a finished response is held
	assign adv = !rsp_valid_q || !rsp_stall;
	assign req_stall = !adv;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sw_q <= lttm_pkg::RST_SURFACE_WIDTH;
			sh_q <= lttm_pkg::RST_SURFACE_HEIGHT;
			ew_q <= lttm_pkg::RST_ENGINE_WIDTH;
			eh_q <= lttm_pkg::RST_ENGINE_HEIGHT;
		end else if (wr_en) begin
			case (lttm_pkg::reg_idx_t'(wr_index))
				lttm_pkg::REG_SURFACE_WIDTH:  sw_q <= wr_data;
				lttm_pkg::REG_SURFACE_HEIGHT: sh_q <= wr_data;
				lttm_pkg::REG_ENGINE_WIDTH:   ew_q <= wr_data;
				lttm_pkg::REG_ENGINE_HEIGHT:  eh_q <= wr_data;
				default: ;
			endcase
		end
	end

	// effective sizes: saturate, zero engine size follows the surface
	assign sw = lttm_pkg::sat_dim(sw_q);
	assign sh = lttm_pkg::sat_dim(sh_q);
	assign ew = (ew_q != '0) ? lttm_pkg::sat_dim(ew_q) : sw;
	assign eh = (eh_q != '0) ? lttm_pkg::sat_dim(eh_q) : sh;

	// s2 operand select: width limited when sw*eh < sh*ew
	always_comb begin
		wlim_c = pa_s1 < pb_s1;
		psel = wlim_c ? pa_s1 : pb_s1;
		dsel = wlim_c ? {side_s1.ew, 1'b0} : {side_s1.eh, 1'b0};
		side_c2 = side_s1;
		side_c2.wlim = wlim_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= req_valid;
			v_s2 <= v_s1;
			v_s3 <= rv;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			// s1: cross products
			pa_s1 <= (2*DW)'(sw) * (2*DW)'(eh);
			pb_s1 <= (2*DW)'(sh) * (2*DW)'(ew);
			side_s1 <= '{sw: sw, sh: sh, ew: ew, eh: eh, wlim: 1'b0,
				fit: (sw != '0) && (sh != '0), x: surface_x, y: surface_y};
			// s2: rounded-division operands, 2*p + e over 2*e
			side_s2 <= side_c2;
			if (side_s1.fit) begin
				num_s2 <= {psel, 1'b0}
					+ lttm_pkg::RDIV_NUM_W'(dsel[lttm_pkg::RDIV_DEN_W-1:1]);
				den_s2 <= dsel;
			end else begin
				num_s2 <= '0;
				den_s2 <= lttm_pkg::RDIV_DEN_W'(1);
			end
			// s3: fitted rectangle
			x_s3 <= rside.x;
			y_s3 <= rside.y;
			w_s3 <= w_c;
			h_s3 <= h_c;
			left_s3 <= dw_c[DW-1:1];
			top_s3 <= dh_c[DW-1:1];
			ew_s3 <= rside.ew;
			eh_s3 <= rside.eh;
		end
	end

	lttm_div #(
		.DEN_W(lttm_pkg::RDIV_DEN_W),
		.Q_W(lttm_pkg::RDIV_Q_W),
		.SIDE_W($bits(lttm_pkg::rdiv_side_t))
	) u_rdiv (
		.clk(clk),
		.arst_n(arst_n),
		.en(adv),
		.in_valid(v_s2),
		.num(num_s2),
		.den(den_s2),
		.side(side_s2),
		.out_valid(rv),
		.quot(rq),
		.out_side(rside)
	);

	// rectangle from the quotient; no fitting with a zero surface side
	always_comb begin
		w_c = rside.sw;
		h_c = rside.sh;
		if (rside.fit) begin
			if (rside.wlim) begin
				h_c = rq;
			end else begin
				w_c = rq;
			end
		end
		dw_c = rside.sw - w_c;
		dh_c = rside.sh - h_c;
	end

	lttm_lane u_lane_x (
		.clk(clk),
		.arst_n(arst_n),
		.en(adv),
		.in_valid(v_s3),
		.coord(x_s3),
		.offset(left_s3),
		.len(w_s3),
		.eng(ew_s3),
		.out_valid(xv),
		.mapped(xm),
		.raw(xraw),
		.out_offset(xoff),
		.out_len(xlen)
	);

	lttm_lane u_lane_y (
		.clk(clk),
		.arst_n(arst_n),
		.en(adv),
		.in_valid(v_s3),
		.coord(y_s3),
		.offset(top_s3),
		.len(h_s3),
		.eng(eh_s3),
		.out_valid(yv),
		.mapped(ym),
		.raw(yraw),
		.out_offset(yoff),
		.out_len(ylen)
	);

	// merge: raw pass-through when the rectangle is empty
	assign degen = (xlen == '0) || (ylen == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (adv) begin
			rsp_valid_q <= xv && yv;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ex_q <= degen ? xraw : $signed({{(CW-DW){1'b0}}, xm});
			ey_q <= degen ? yraw : $signed({{(CW-DW){1'b0}}, ym});
			left_q <= xoff;
			top_q <= yoff;
			w_q <= xlen;
			h_q <= ylen;
			degen_q <= degen;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign engine_x = ex_q;
	assign engine_y = ey_q;
	assign rect_left = left_q;
	assign rect_top = top_q;
	assign rect_width = w_q;
	assign rect_height = h_q;
	assign degenerate = degen_q;

endmodule
`default_nettype wire

@@ hdl/lttm_chk.sv @@
`default_nettype none
`include "letterbox_touch_mapper_unit_defines.svh"
// Port-level checks on the touch mapper.
module lttm_chk (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic req_valid,
	input wire logic req_stall,
	input wire logic signed [lttm_pkg::COORD_W-1:0] surface_x,
	input wire logic signed [lttm_pkg::COORD_W-1:0] surface_y,
	input wire logic rsp_valid,
	input wire logic rsp_stall,
	input wire logic signed [lttm_pkg::COORD_W-1:0] engine_x,
	input wire logic signed [lttm_pkg::COORD_W-1:0] engine_y,
	input wire logic [lttm_pkg::OFF_W-1:0] rect_left,
	input wire logic [lttm_pkg::OFF_W-1:0] rect_top,
	input wire logic [lttm_pkg::DIM_W-1:0] rect_width,
	input wire logic [lttm_pkg::DIM_W-1:0] rect_height,
	input wire logic degenerate,
	input wire logic wr_en,
	input wire logic [lttm_pkg::REG_IDX_W-1:0] wr_index,
	input wire logic [lttm_pkg::DIM_W-1:0] wr_data
);
	// intake stalls exactly when a response is held
	`LTTM_ASSERT_NOW(a_stall_tie, 1'b1, req_stall == (rsp_valid && rsp_stall))
	// degenerate flag matches the reported rectangle
	`LTTM_ASSERT_NOW(a_degen, rsp_valid, degenerate == ((rect_width == '0) || (rect_height == '0)))
	// mapped points are never negative
	`LTTM_ASSERT_NOW(a_nonneg, rsp_valid && !degenerate, !engine_x[14] && !engine_y[14])
	// a held response stays up
	`LTTM_ASSERT_NEXT(a_hold, rsp_valid && rsp_stall, rsp_valid)
endmodule

bind letterbox_touch_mapper_unit lttm_chk u_chk (.*);
`default_nettype wire

@@ verif/tb.sv @@
`default_nettype none
module tb;
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	logic signed [lttm_pkg::COORD_W-1:0] surface_x = '0;
	logic signed [lttm_pkg::COORD_W-1:0] surface_y = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	logic signed [lttm_pkg::COORD_W-1:0] engine_x, engine_y;
	logic [lttm_pkg::OFF_W-1:0] rect_left, rect_top;
	logic [lttm_pkg::DIM_W-1:0] rect_width, rect_height;
	logic degenerate;
	logic wr_en = 1'b0;
	logic [lttm_pkg::REG_IDX_W-1:0] wr_index = '0;
	logic [lttm_pkg::DIM_W-1:0] wr_data = '0;

	typedef struct packed {
		logic [lttm_pkg::COORD_W-1:0] ex;
		logic [lttm_pkg::COORD_W-1:0] ey;
		logic [lttm_pkg::OFF_W-1:0] left;
		logic [lttm_pkg::OFF_W-1:0] top;
		logic [lttm_pkg::DIM_W-1:0] w;
		logic [lttm_pkg::DIM_W-1:0] h;
		logic degen;
	} mapped_t;

	mapped_t mapped_q[$];
	logic [lttm_pkg::DIM_W-1:0] surf_w_r, surf_h_r, eng_w_r, eng_h_r;
	int errors = 0;
	int send_idle_pct = 0;
	int stall_pct = 0;

	letterbox_touch_mapper_unit DUT (.*);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic longint map_lane(longint c, longint off, longint eng, longint len);
		longint d, r;
		d = c - off;
		if (d <= 0) return 0;
		r = (d * eng) / len;
		return (r > eng - 1) ? eng - 1 : r;
	endfunction

	// Predicted mapping of one touch point under the current registers
	function automatic mapped_t map_touch(logic [lttm_pkg::COORD_W-1:0] px,
			logic [lttm_pkg::COORD_W-1:0] py);
		longint sw, sh, ew, eh, w, h, lf, tp;
		mapped_t m;
		sw = surf_w_r; sh = surf_h_r;
		ew = (eng_w_r != 0) ? eng_w_r : sw;
		eh = (eng_h_r != 0) ? eng_h_r : sh;
		w = sw; h = sh; lf = 0; tp = 0;
		if (sw != 0 && sh != 0 && ew != 0 && eh != 0) begin
			if (sw * eh < sh * ew) begin
				h = (2 * eh * sw + ew) / (2 * ew);
			end else begin
				w = (2 * ew * sh + eh) / (2 * eh);
			end
			lf = (sw - w) / 2;
			tp = (sh - h) / 2;
		end
		m.degen = (w == 0 || h == 0);
		if (m.degen) begin
			m.ex = px;
			m.ey = py;
		end else begin
			m.ex = lttm_pkg::COORD_W'(map_lane(longint'($signed(px)), lf, ew, w));
			m.ey = lttm_pkg::COORD_W'(map_lane(longint'($signed(py)), tp, eh, h));
		end
		m.left = lttm_pkg::OFF_W'(lf); m.top = lttm_pkg::OFF_W'(tp);
		m.w = lttm_pkg::DIM_W'(w); m.h = lttm_pkg::DIM_W'(h);
		return m;
	endfunction

	// Receiver stall and response checking
	always @(posedge clk) begin
		mapped_t e;
		if (arst_n) begin
			if (rsp_valid && !rsp_stall) begin
				if (mapped_q.size() == 0) begin
					$error("unexpected response");
					errors++;
				end else begin
					e = mapped_q.pop_front();
					if (engine_x !== e.ex) begin
						$error("engine_x exp %0h got %0h", e.ex, engine_x); errors++;
					end
					if (engine_y !== e.ey) begin
						$error("engine_y exp %0h got %0h", e.ey, engine_y); errors++;
					end
					if (rect_left !== e.left) begin
						$error("rect_left exp %0d got %0d", e.left, rect_left); errors++;
					end
					if (rect_top !== e.top) begin
						$error("rect_top exp %0d got %0d", e.top, rect_top); errors++;
					end
					if (rect_width !== e.w) begin
						$error("rect_width exp %0d got %0d", e.w, rect_width); errors++;
					end
					if (rect_height !== e.h) begin
						$error("rect_height exp %0d got %0d", e.h, rect_height); errors++;
					end
					if (degenerate !== e.degen) begin
						$error("degenerate exp %0b got %0b", e.degen, degenerate); errors++;
					end
				end
			end
			rsp_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// Send one request, with optional idle cycles before it
	task automatic send_touch(logic [lttm_pkg::COORD_W-1:0] px,
			logic [lttm_pkg::COORD_W-1:0] py);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		surface_x <= px;
		surface_y <= py;
		mapped_q.push_back(map_touch(px, py));
		do @(posedge clk); while (req_stall);
	endtask

	task automatic drain;
		req_valid <= 1'b0;
		while (mapped_q.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_reg(lttm_pkg::reg_idx_t idx, logic [lttm_pkg::DIM_W-1:0] val);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		@(posedge clk);
		case (idx)
			lttm_pkg::REG_SURFACE_WIDTH:  surf_w_r = val;
			lttm_pkg::REG_SURFACE_HEIGHT: surf_h_r = val;
			lttm_pkg::REG_ENGINE_WIDTH:   eng_w_r = val;
			default:                      eng_h_r = val;
		endcase
	endtask

	task automatic set_geometry(logic [lttm_pkg::DIM_W-1:0] sw, logic [lttm_pkg::DIM_W-1:0] sh,
			logic [lttm_pkg::DIM_W-1:0] ew, logic [lttm_pkg::DIM_W-1:0] eh);
		drain();
		write_reg(lttm_pkg::REG_SURFACE_WIDTH, sw);
		write_reg(lttm_pkg::REG_SURFACE_HEIGHT, sh);
		write_reg(lttm_pkg::REG_ENGINE_WIDTH, ew);
		write_reg(lttm_pkg::REG_ENGINE_HEIGHT, eh);
		wr_en <= 1'b0;
	endtask

	// Edge coordinates under the reset geometry and a few extreme ones
	task automatic test_directed;
		send_touch(15'h0000, 15'h0000);
		send_touch(15'h3FFF, 15'h3FFF);
		send_touch(15'h4000, 15'h4000);
		send_touch(15'h7FFF, 15'h0200);
		set_geometry(13'd1920, 13'd1080, 13'd640, 13'd480);
		send_touch(15'd240, 15'd540);
		send_touch(15'd1679, 15'd1079);
		send_touch(15'd1680, 15'd1080);
		set_geometry(13'd8191, 13'd8191, 13'd1, 13'd8191);
		send_touch(15'd4095, 15'd100);
		send_touch(15'h3FFF, 15'h7FFF);
		// zero surface height leaves the rectangle empty
		set_geometry(13'd640, 13'd0, 13'd0, 13'd0);
		send_touch(15'h1234, 15'h5678);
		send_touch(15'h7FFF, 15'h4000);
		// fit rounds the rectangle down to nothing
		set_geometry(13'd1, 13'd8191, 13'd8191, 13'd1);
		send_touch(15'h2AAA, 15'h5555);
		set_geometry(13'd1, 13'd1, 13'd8191, 13'd8191);
		send_touch(15'd0, 15'd1);
		send_touch(15'h7FFF, 15'h3FFF);
	endtask

	function automatic logic [lttm_pkg::DIM_W-1:0] pick_dim(bit allow_zero);
		case ($urandom_range(5))
			0: return allow_zero ? 13'd0 : 13'd1;
			1: return 13'd8191;
			2: return lttm_pkg::DIM_W'($urandom_range(1, 16));
			default: return lttm_pkg::DIM_W'($urandom_range(1, 8191));
		endcase
	endfunction

	// Random geometries and touch points under several idle and stall mixes
	task automatic test_random;
		logic [lttm_pkg::COORD_W-1:0] px, py;
		for (int ph = 0; ph < 25; ph++) begin
			case (ph % 5)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 54; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 54; end
				3: begin send_idle_pct = 9;  stall_pct = 9;  end
				default: begin send_idle_pct = 0; stall_pct = 0; end
			endcase
			set_geometry(($urandom_range(19) == 0) ? 13'd0 : pick_dim(0),
				($urandom_range(19) == 0) ? 13'd0 : pick_dim(0), pick_dim(1), pick_dim(1));
			for (int i = 0; i < 50; i++) begin
				if ($urandom_range(3) == 0) begin
					px = lttm_pkg::COORD_W'($urandom);
					py = lttm_pkg::COORD_W'($urandom);
				end else begin
					px = lttm_pkg::COORD_W'($urandom_range(surf_w_r + 20)) - 15'd10;
					py = lttm_pkg::COORD_W'($urandom_range(surf_h_r + 20)) - 15'd10;
				end
				send_touch(px, py);
			end
		end
		send_idle_pct = 0;
		stall_pct = 0;
	endtask

	initial begin
		surf_w_r = lttm_pkg::RST_SURFACE_WIDTH;
		surf_h_r = lttm_pkg::RST_SURFACE_HEIGHT;
		eng_w_r = lttm_pkg::RST_ENGINE_WIDTH;
		eng_h_r = lttm_pkg::RST_ENGINE_HEIGHT;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random();
		drain();
		if (errors == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

	initial begin
		#4000000;
		$display("TEST FAILED");
		$finish;
	end
endmodule
`default_nettype wire
